@@ hdl/csts_pkg.sv @@
// Shared types, character codes and token helpers for the C subset token scanner.
package csts_pkg;

   localparam int MAX_RES     = 4;
   localparam int PUSH_W      = $clog2(MAX_RES + 1);
   localparam int QUEUE_DEPTH = 8;
   localparam int KW_LEN_MAX  = 6;

   localparam logic [3:0] KIND_INT     = 4'd0;
   localparam logic [3:0] KIND_REAL    = 4'd1;
   localparam logic [3:0] KIND_IDENT   = 4'd2;
   localparam logic [3:0] KIND_KEYWORD = 4'd3;
   localparam logic [3:0] KIND_RETURN  = 4'd4;
   localparam logic [3:0] KIND_PLUS    = 4'd5;
   localparam logic [3:0] KIND_MINUS   = 4'd6;
   localparam logic [3:0] KIND_STAR    = 4'd7;
   localparam logic [3:0] KIND_SLASH   = 4'd8;
   localparam logic [3:0] KIND_LBRACE  = 4'd9;
   localparam logic [3:0] KIND_RBRACE  = 4'd10;
   localparam logic [3:0] KIND_LPAREN  = 4'd11;
   localparam logic [3:0] KIND_RPAREN  = 4'd12;
   localparam logic [3:0] KIND_COMMA   = 4'd13;
   localparam logic [3:0] KIND_SEMI    = 4'd14;
   localparam logic [3:0] KIND_END     = 4'd15;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   localparam logic [47:0] KW_RETURN = "return";
   localparam logic [47:0] KW_DOUBLE = "double";
   localparam logic [31:0] KW_CHAR   = "char";
   localparam logic [31:0] KW_VOID   = "void";
   localparam logic [23:0] KW_INT    = "int";

   typedef enum logic [2:0] {
      MODE_WS,
      MODE_ID,
      MODE_NUM,
      MODE_LINE,
      MODE_BLOCK
   } scan_mode_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_SLASH,
      HOLD_CR
   } held_type;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [PUSH_W-1:0]         count;
      rsp_type [MAX_RES-1:0]     tok;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] kind;
   } single_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic single_type single_kind(input logic [7:0] c);
      single_type r;
      r.hit = 1'b1;
      case (c)
         "+": r.kind = KIND_PLUS;
         "-": r.kind = KIND_MINUS;
         "*": r.kind = KIND_STAR;
         "{": r.kind = KIND_LBRACE;
         "}": r.kind = KIND_RBRACE;
         "(": r.kind = KIND_LPAREN;
         ")": r.kind = KIND_RPAREN;
         ",": r.kind = KIND_COMMA;
         ";": r.kind = KIND_SEMI;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_IDENT;
         end
      endcase
      return r;
   endfunction

   // only the leading len characters are compared, so unwritten entries never matter
   function automatic logic [3:0] id_kind(input logic [7:0] kw [KW_LEN_MAX],
                                          input logic len3, input logic len4,
                                          input logic len6);
      logic [47:0] w6;
      logic [31:0] w4;
      logic [23:0] w3;
      logic [3:0]  k;
      w6 = {kw[0], kw[1], kw[2], kw[3], kw[4], kw[5]};
      w4 = {kw[0], kw[1], kw[2], kw[3]};
      w3 = {kw[0], kw[1], kw[2]};
      k  = KIND_IDENT;
      if (len6 && w6 == KW_RETURN) begin
         k = KIND_RETURN;
      end else if (len3 && w3 == KW_INT) begin
         k = KIND_KEYWORD;
      end else if (len6 && w6 == KW_DOUBLE) begin
         k = KIND_KEYWORD;
      end else if (len4 && (w4 == KW_CHAR || w4 == KW_VOID)) begin
         k = KIND_KEYWORD;
      end
      return k;
   endfunction

endpackage

@@ hdl/csts_scan.sv @@
// Scanner state and per-byte token generation; one byte per accepted transaction.
module csts_scan import csts_pkg::*; #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_CHARS = 6
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  req_type  req_data,
   output push_type push
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   scan_mode_type            mode_ff, mode_in;
   held_type                 held_ff, held_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] len_ff, len_in;
   logic                     dot_ff, dot_in;
   logic                     star_ff, star_in;
   logic [7:0]               pref_ff [KEYWORD_CHARS];
   logic [7:0]               pref_in [KEYWORD_CHARS];

   always_comb begin
      logic [7:0]               c;
      logic                     fin;
      logic                     done;
      logic                     run_ws;
      logic [PUSH_W-1:0]        n;
      logic [POSITION_BITS-1:0] p;
      logic [POSITION_BITS-1:0] p_next;
      logic [7:0]               kw [KW_LEN_MAX];
      single_type               sk;

      c        = req_data.src_byte;
      fin      = req_data.final_byte;
      p        = pos_ff;
      done     = 1'b0;
      run_ws   = 1'b0;
      n        = '0;
      mode_in  = mode_ff;
      held_in  = held_ff;
      start_in = start_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      star_in  = star_ff;
      pref_in  = pref_ff;
      push     = '0;
      sk       = single_kind(c);

      // lookahead on a held slash or CR
      if (held_in == HOLD_SLASH) begin
         held_in = HOLD_NONE;
         if (c == CH_SLASH) begin
            mode_in = MODE_LINE;
            done    = 1'b1;
         end else if (c == CH_STAR) begin
            mode_in = MODE_BLOCK;
            star_in = 1'b0;
            done    = 1'b1;
         end else begin
            push.tok[n[1:0]].token_kind   = KIND_SLASH;
            push.tok[n[1:0]].token_start  = 16'(start_in);
            push.tok[n[1:0]].token_length = 16'd1;
            n = n + 1'b1;
         end
      end else if (held_in == HOLD_CR) begin
         held_in = HOLD_NONE;
         if (c == CH_LF) begin
            mode_in = MODE_WS;
            done    = 1'b1;
         end
      end else begin
         held_in = HOLD_NONE;
      end

      for (int i = 0; i < KW_LEN_MAX; i++) begin
         kw[i] = pref_in[i];
      end

      if (!done) begin
         case (mode_in)
            MODE_ID: begin
               if (is_alpha(c) || is_digit(c)) begin
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (len_in == POSITION_BITS'(i)) begin
                        pref_in[i] = c;
                     end
                  end
                  len_in = (len_in == POS_MAX) ? len_in : len_in + 1'b1;
               end else begin
                  push.tok[n[1:0]].token_kind   = id_kind(kw,
                     len_in == POSITION_BITS'(3), len_in == POSITION_BITS'(4),
                     len_in == POSITION_BITS'(6));
                  push.tok[n[1:0]].token_start  = 16'(start_in);
                  push.tok[n[1:0]].token_length = 16'(len_in);
                  n       = n + 1'b1;
                  mode_in = MODE_WS;
                  run_ws  = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(c) || c == CH_DOT) begin
                  if (c == CH_DOT) begin
                     dot_in = 1'b1;
                  end
                  len_in = (len_in == POS_MAX) ? len_in : len_in + 1'b1;
               end else begin
                  push.tok[n[1:0]].token_kind   = dot_in ? KIND_REAL : KIND_INT;
                  push.tok[n[1:0]].token_start  = 16'(start_in);
                  push.tok[n[1:0]].token_length = 16'(len_in);
                  n       = n + 1'b1;
                  mode_in = MODE_WS;
                  run_ws  = 1'b1;
               end
            end
            MODE_LINE: begin
               if (c == CH_CR) begin
                  held_in = HOLD_CR;
               end
            end
            MODE_BLOCK: begin
               if (c == CH_SLASH && star_in) begin
                  mode_in = MODE_WS;
               end
               star_in = (c == CH_STAR);
            end
            default: begin
               run_ws = 1'b1;
            end
         endcase
      end

      if (run_ws) begin
         mode_in = MODE_WS;
         if (c == CH_CR) begin
            held_in = HOLD_CR;
         end else if (c == CH_SLASH) begin
            held_in  = HOLD_SLASH;
            start_in = p;
         end else if (sk.hit) begin
            push.tok[n[1:0]].token_kind   = sk.kind;
            push.tok[n[1:0]].token_start  = 16'(p);
            push.tok[n[1:0]].token_length = 16'd1;
            n = n + 1'b1;
         end else if (is_digit(c)) begin
            mode_in  = MODE_NUM;
            start_in = p;
            len_in   = POSITION_BITS'(1);
            dot_in   = 1'b0;
         end else if (is_alpha(c)) begin
            mode_in    = MODE_ID;
            start_in   = p;
            len_in     = POSITION_BITS'(1);
            pref_in[0] = c;
         end
      end

      p_next = (p == POS_MAX) ? p : p + 1'b1;
      pos_in = p_next;

      if (fin) begin
         if (held_in == HOLD_SLASH) begin
            push.tok[n[1:0]].token_kind   = KIND_SLASH;
            push.tok[n[1:0]].token_start  = 16'(start_in);
            push.tok[n[1:0]].token_length = 16'd1;
            n = n + 1'b1;
         end
         for (int i = 0; i < KW_LEN_MAX; i++) begin
            kw[i] = pref_in[i];
         end
         if (mode_in == MODE_ID || mode_in == MODE_NUM) begin
            push.tok[n[1:0]].token_kind   = (mode_in == MODE_NUM) ?
               (dot_in ? KIND_REAL : KIND_INT) :
               id_kind(kw, len_in == POSITION_BITS'(3), len_in == POSITION_BITS'(4),
                       len_in == POSITION_BITS'(6));
            push.tok[n[1:0]].token_start  = 16'(start_in);
            push.tok[n[1:0]].token_length = 16'(len_in);
            n = n + 1'b1;
         end
         push.tok[n[1:0]].token_kind   = KIND_END;
         push.tok[n[1:0]].token_start  = 16'(p_next);
         push.tok[n[1:0]].token_length = 16'd0;
         n = n + 1'b1;
         // back to the start of a fresh source
         mode_in  = MODE_WS;
         held_in  = HOLD_NONE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         dot_in   = 1'b0;
         star_in  = 1'b0;
      end

      if (n != '0) begin
         push.tok[n[1:0] - 2'd1].last_of_run = 1'b1;
      end
      push.count = req_fire ? n : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WS;
         held_ff  <= HOLD_NONE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
         star_ff  <= 1'b0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         star_ff  <= star_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pref_ff <= pref_in;
      end
   end

endmodule

@@ hdl/csts_queue.sv @@
// Output token queue; takes up to four tokens per cycle and releases one per cycle while rsp_ready is high.
module csts_queue import csts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ff];
   // room for a full run of tokens from the next transaction
   assign space_ok  = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_RES));

   always_comb begin
      wr_in    = wr_ff + PTR_W'(push.count);
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (PUSH_W'(i) < push.count) begin
            mem_ff[wr_ff + PTR_W'(i)] <= push.tok[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/c_subset_token_scanner.sv @@
// Token scanner for a small C subset: one source byte in, up to four tokens out.
// A byte's tokens are registered in the token queue and leave on rsp in order.
// Throughput: one byte per cycle while req_ready is high; tokens leave one per cycle
// while rsp_ready is high; req_ready drops with fewer than four free queue entries.
// Reset (synchronous): scanner back to whitespace mode at offset 0, queue emptied.
module c_subset_token_scanner import csts_pkg::*; #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_CHARS = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   push_type push;
   logic     req_fire;

   assign req_fire = req_valid && req_ready;

   csts_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .push     (push)
   );

   csts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_c_subset_token_scanner.sv @@
// Testbench for the C subset token scanner: directed and random sources checked against a token predictor.
`timescale 1ns / 1ps

module tb_c_subset_token_scanner;
   import csts_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   // Tracks the scanner state per accepted byte and holds the tokens still owed by the block.
   class token_tracker;
      scan_mode_type mode;
      held_type      held;
      logic [15:0]   pos;
      logic [15:0]   tok_start;
      logic [15:0]   tok_len;
      logic [7:0]    prefix [KW_LEN_MAX];
      logic          dot_seen;
      logic          star_prev;
      rsp_type       burst [$];
      rsp_type       pending_tokens [$];
      int            mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode      = MODE_WS;
         held      = HOLD_NONE;
         pos       = '0;
         tok_start = '0;
         tok_len   = '0;
         dot_seen  = 1'b0;
         star_prev = 1'b0;
         foreach (prefix[i]) prefix[i] = '0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function bit letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit numeral(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function void push(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
         rsp_type t;
         if (burst.size() >= MAX_RES) return;
         t.token_kind   = kind;
         t.token_start  = start;
         t.token_length = len;
         t.last_of_run  = 1'b0;
         burst.push_back(t);
      endfunction

      function void close_token();
         string      w;
         logic [3:0] kind;
         if (mode == MODE_NUM) begin
            kind = dot_seen ? KIND_REAL : KIND_INT;
         end else if (mode == MODE_ID) begin
            kind = KIND_IDENT;
            // only identifiers no longer than the stored prefix can be keywords
            if (tok_len <= KW_LEN_MAX) begin
               w = "";
               for (int i = 0; i < tok_len; i++) w = $sformatf("%s%c", w, prefix[i]);
               if (w == "return") kind = KIND_RETURN;
               else if (w == "int" || w == "double" || w == "char" || w == "void")
                  kind = KIND_KEYWORD;
            end
         end else begin
            return;
         end
         push(kind, tok_start, tok_len);
         mode = MODE_WS;
      endfunction

      function void ws_byte(logic [7:0] c, logic [15:0] p);
         logic [3:0] kind;
         bit         hit;
         hit = 1'b1;
         case (c)
            "+": kind = KIND_PLUS;
            "-": kind = KIND_MINUS;
            "*": kind = KIND_STAR;
            "{": kind = KIND_LBRACE;
            "}": kind = KIND_RBRACE;
            "(": kind = KIND_LPAREN;
            ")": kind = KIND_RPAREN;
            ",": kind = KIND_COMMA;
            ";": kind = KIND_SEMI;
            default: begin
               hit  = 1'b0;
               kind = KIND_IDENT;
            end
         endcase
         mode = MODE_WS;
         if (c == CH_CR) begin
            held = HOLD_CR;
         end else if (c == CH_SLASH) begin
            held      = HOLD_SLASH;
            tok_start = p;
         end else if (hit) begin
            push(kind, p, 16'd1);
         end else if (numeral(c)) begin
            mode      = MODE_NUM;
            tok_start = p;
            tok_len   = 16'd1;
            dot_seen  = 1'b0;
         end else if (letter(c)) begin
            mode      = MODE_ID;
            tok_start = p;
            tok_len   = 16'd1;
            prefix[0] = c;
         end
      endfunction

      function void note_byte(req_type r);
         logic [7:0]  c;
         logic [15:0] p;
         bit          consumed;
         c        = r.src_byte;
         p        = pos;
         consumed = 1'b0;
         burst.delete();
         if (held == HOLD_SLASH) begin
            held = HOLD_NONE;
            if (c == CH_SLASH) begin
               mode     = MODE_LINE;
               consumed = 1'b1;
            end else if (c == CH_STAR) begin
               mode      = MODE_BLOCK;
               star_prev = 1'b0;
               consumed  = 1'b1;
            end else begin
               push(KIND_SLASH, tok_start, 16'd1);
            end
         end else if (held == HOLD_CR) begin
            // a CR without LF just vanishes
            held = HOLD_NONE;
            if (c == CH_LF) begin
               mode     = MODE_WS;
               consumed = 1'b1;
            end
         end
         if (!consumed) begin
            case (mode)
               MODE_ID: begin
                  if (letter(c) || numeral(c)) begin
                     if (tok_len < KW_LEN_MAX) prefix[tok_len] = c;
                     tok_len = bump(tok_len);
                  end else begin
                     close_token();
                     ws_byte(c, p);
                  end
               end
               MODE_NUM: begin
                  if (numeral(c) || c == CH_DOT) begin
                     if (c == CH_DOT) dot_seen = 1'b1;
                     tok_len = bump(tok_len);
                  end else begin
                     close_token();
                     ws_byte(c, p);
                  end
               end
               MODE_LINE: begin
                  if (c == CH_CR) held = HOLD_CR;
               end
               MODE_BLOCK: begin
                  if (c == CH_SLASH && star_prev) mode = MODE_WS;
                  star_prev = (c == CH_STAR);
               end
               default: ws_byte(c, p);
            endcase
         end
         pos = bump(p);
         if (r.final_byte) begin
            if (held == HOLD_SLASH) push(KIND_SLASH, tok_start, 16'd1);
            held = HOLD_NONE;
            close_token();
            push(KIND_END, pos, 16'd0);
            clear_state();
         end
         if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
         foreach (burst[i]) pending_tokens.push_back(burst[i]);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_token(rsp_type got);
         rsp_type want;
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("token with nothing pending: kind %0d start %0d length %0d",
                                      got.token_kind, got.token_start, got.token_length));
            return;
         end
         want = pending_tokens.pop_front();
         if (got.token_kind !== want.token_kind)
            report_mismatch($sformatf("kind %0d, wanted %0d (start %0d)",
                                      got.token_kind, want.token_kind, want.token_start));
         if (got.token_start !== want.token_start)
            report_mismatch($sformatf("start %0d, wanted %0d (kind %0d)",
                                      got.token_start, want.token_start, want.token_kind));
         if (got.token_length !== want.token_length)
            report_mismatch($sformatf("length %0d, wanted %0d (kind %0d start %0d)",
                                      got.token_length, want.token_length,
                                      want.token_kind, want.token_start));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, wanted %0b (kind %0d start %0d)",
                                      got.last_of_run, want.last_of_run,
                                      want.token_kind, want.token_start));
      endtask
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit           gaps_on      = 1'b1;
   int           quiet_cycles = 0;
   logic [7:0]   src_text [$];
   token_tracker tracker;

   c_subset_token_scanner u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 31);
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) tracker.note_byte(req_data);
      if (!reset && rsp_valid && rsp_ready) tracker.check_token(rsp_data);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void add_byte(input logic [7:0] b);
      src_text.push_back(b);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return 8'((r < 26) ? "a" + r : "A" + r - 26);
   endfunction

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(61);
      if (r < 52) return 8'((r < 26) ? "a" + r : "A" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   function automatic string pick_keyword();
      case ($urandom_range(4))
         0: return "return";
         1: return "int";
         2: return "double";
         3: return "char";
         default: return "void";
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (gaps_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // the last byte of the source carries final_byte
   task automatic send_source();
      foreach (src_text[i]) send_byte(src_text[i], i == src_text.size() - 1);
      src_text.delete();
   endtask

   task automatic wait_for_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_tokens.size() != 0) @(posedge clock);
   endtask

   initial begin
      string kw;
      int    sel;
      int    random_bytes;
      tracker      = new();
      random_bytes = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every operator, punctuation, keyword kinds, int and real
      add_text("int f(x,2.5){return 7/y-z*w+0;}");
      send_source();
      // "/*/" stays open, line comment to CRLF, unknown bytes, lone CR, held slash at end
      add_text("/*/*/a//b");
      add_byte(CH_CR);
      add_byte(CH_LF);
      add_byte(8'h09);
      add_byte(CH_CR);
      add_text("=");
      add_byte(8'h00);
      add_byte(8'hA5);
      add_byte(CH_SLASH);
      send_source();
      // unterminated block comment, then a source of one byte
      add_text("/*");
      send_source();
      add_byte(8'hFF);
      send_source();
      wait_for_tokens();

      while (random_bytes < 400) begin
         gaps_on <= !(random_bytes >= 180 && random_bytes < 300);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 14)) begin
               sel = $urandom_range(15);
               case (sel)
                  0: add_text(pick_keyword());
                  1: begin
                     // near misses of keywords
                     kw = pick_keyword();
                     if ($urandom_range(1)) begin
                        add_text(kw.substr(0, kw.len() - 2));
                     end else begin
                        add_text(kw);
                        add_byte(rand_alnum());
                     end
                  end
                  2, 3: begin
                     add_byte(rand_letter());
                     repeat ($urandom_range(7)) add_byte(rand_alnum());
                  end
                  4, 5: begin
                     add_byte(8'("0" + $urandom_range(9)));
                     repeat ($urandom_range(5))
                        add_byte(($urandom_range(3) == 0) ? CH_DOT :
                                 8'("0" + $urandom_range(9)));
                  end
                  6, 7, 8: begin
                     kw = "+-*/{}(),;";
                     add_byte(kw[$urandom_range(9)]);
                  end
                  9, 10: repeat ($urandom_range(1, 2)) add_byte(" ");
                  11: begin
                     add_byte(CH_CR);
                     add_byte(CH_LF);
                  end
                  12: begin
                     add_text("//");
                     repeat ($urandom_range(6)) add_byte(8'($urandom_range(32, 126)));
                     if ($urandom_range(3) == 0) add_byte(CH_CR);
                     add_byte(CH_CR);
                     add_byte(CH_LF);
                  end
                  13: begin
                     add_text("/*");
                     kw = "*/ab ";
                     repeat ($urandom_range(6)) add_byte(kw[$urandom_range(4)]);
                     add_text("*/");
                  end
                  default: begin
                     case ($urandom_range(5))
                        0: add_byte(8'h09);
                        1: add_byte(CH_LF);
                        2: add_byte(CH_DOT);
                        3: add_text("=");
                        4: add_byte(CH_CR);
                        default: add_byte(8'($urandom_range(255)));
                     endcase
                  end
               endcase
               if (sel <= 5 && $urandom_range(2) != 0) add_byte(" ");
            end
         end
         random_bytes += src_text.size();
         send_source();
      end

      wait_for_tokens();
      // leave room for stray tokens before the final check
      repeat (8) @(posedge clock);
      if (tracker.pending_tokens.size() != 0)
         tracker.report_mismatch($sformatf("%0d tokens never arrived",
                                           tracker.pending_tokens.size()));
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
